@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros for the stack unit
// concurrent checks compile away when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge out of reset
`define FBSU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fbsu assertion failed");
// condition never seen out of reset
`define FBSU_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fbsu forbidden condition seen");
`else
`define FBSU_ASSERT(lbl, clk, rst_n, prop)
`define FBSU_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ design/fbsu_pkg.sv @@
// ---------------------------------------------------------------------------
// fbsu_pkg
// opcodes, command format and state types shared by the stack unit
// ---------------------------------------------------------------------------
package fbsu_pkg;

  localparam logic [7:0] OPC_NPUSHB    = 8'h40;
  localparam logic [7:0] OPC_NPUSHW    = 8'h41;
  localparam logic [7:0] OPC_PUSHB     = 8'hB0;
  localparam logic [7:0] OPC_PUSHW     = 8'hB8;
  localparam logic [7:0] OPC_PUSH_MASK = 8'hF8;
  localparam logic [7:0] OPC_DUP       = 8'h20;
  localparam logic [7:0] OPC_POP       = 8'h21;
  localparam logic [7:0] OPC_CLEAR     = 8'h22;
  localparam logic [7:0] OPC_SWAP      = 8'h23;
  localparam logic [7:0] OPC_CINDEX    = 8'h25;
  localparam logic [7:0] OPC_MINDEX    = 8'h26;
  localparam logic [7:0] OPC_ROLL      = 8'h8A;
  localparam logic [7:0] OPC_LT        = 8'h50;
  localparam logic [7:0] OPC_LTEQ      = 8'h51;
  localparam logic [7:0] OPC_GT        = 8'h52;
  localparam logic [7:0] OPC_GTEQ      = 8'h53;
  localparam logic [7:0] OPC_EQ        = 8'h54;
  localparam logic [7:0] OPC_NEQ       = 8'h55;
  localparam logic [7:0] OPC_AND       = 8'h5A;
  localparam logic [7:0] OPC_OR        = 8'h5B;
  localparam logic [7:0] OPC_NOT       = 8'h5C;
  localparam logic [7:0] OPC_ADD       = 8'h60;
  localparam logic [7:0] OPC_SUB       = 8'h61;
  localparam logic [7:0] OPC_DIV       = 8'h62;
  localparam logic [7:0] OPC_MUL       = 8'h63;
  localparam logic [7:0] OPC_ABS       = 8'h64;
  localparam logic [7:0] OPC_NEG       = 8'h65;
  localparam logic [7:0] OPC_FLOOR     = 8'h66;
  localparam logic [7:0] OPC_CEILING   = 8'h67;
  localparam logic [7:0] OPC_MAX       = 8'h8B;
  localparam logic [7:0] OPC_MIN       = 8'h8C;
  localparam logic [7:0] OPC_WS        = 8'h42;
  localparam logic [7:0] OPC_RS        = 8'h43;
  localparam logic [7:0] OPC_GETINFO   = 8'h88;

  localparam logic [31:0] FRAC_MASK = ~32'd63;
  localparam logic [31:0] CEIL_ADD  = 32'd63;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK, ST_UNDER, ST_OVER, ST_DIV0, ST_BADIDX, ST_UNSUP
  } status_e;

  typedef enum logic [3:0] {
    CMD_NOP, CMD_PUSH, CMD_DUP, CMD_POP, CMD_CLEAR, CMD_SWAP, CMD_CINDEX,
    CMD_MINDEX, CMD_ROLL, CMD_BIN, CMD_UNARY, CMD_WS, CMD_RS, CMD_UNSUP
  } cmd_op_e;

  typedef enum logic [4:0] {
    ALU_LT, ALU_LTEQ, ALU_GT, ALU_GTEQ, ALU_EQ, ALU_NEQ, ALU_AND, ALU_OR,
    ALU_ADD, ALU_SUB, ALU_DIV, ALU_MUL, ALU_MAX, ALU_MIN, ALU_NOT, ALU_ABS,
    ALU_NEG, ALU_FLOOR, ALU_CEIL, ALU_ZERO
  } alu_e;

  typedef struct packed {
    cmd_op_e     op;
    alu_e        alu;
    logic [31:0] val;
    logic        took;
  } cmd_t;

  typedef enum logic [2:0] {
    FS_OPC, FS_CNT_B, FS_CNT_W, FS_BYTE, FS_WHI, FS_WLO
  } front_state_e;

  typedef enum logic [3:0] {
    BS_INIT, BS_IDLE, BS_RD2, BS_EXEC, BS_MUL, BS_DIVWT, BS_MOVE_RD,
    BS_MOVE_WR, BS_WR2, BS_WR3, BS_TOPWT, BS_DONE
  } back_state_e;

endpackage

@@ design/fbsu_front.sv @@
// ---------------------------------------------------------------------------
// fbsu_front
// byte decoder: tracks push counts and payload bytes, classifies opcodes
// ---------------------------------------------------------------------------
module fbsu_front import fbsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] code_byte_i,
  output cmd_t       cmd_o
);

  front_state_e state_q, state_d;
  logic [8:0]   rem_q, rem_d;
  logic [7:0]   hold_q, hold_d;
  logic         push_b, push_w;

  assign push_b = (code_byte_i & OPC_PUSH_MASK) == OPC_PUSHB;
  assign push_w = (code_byte_i & OPC_PUSH_MASK) == OPC_PUSHW;

  function automatic cmd_t classify(logic [7:0] b);
    cmd_t c;
    c.op = CMD_UNSUP;
    c.alu = ALU_ZERO;
    c.val = '0;
    c.took = 1'b0;
    unique case (b)
      OPC_DUP:     c.op = CMD_DUP;
      OPC_POP:     c.op = CMD_POP;
      OPC_CLEAR:   c.op = CMD_CLEAR;
      OPC_SWAP:    c.op = CMD_SWAP;
      OPC_CINDEX:  c.op = CMD_CINDEX;
      OPC_MINDEX:  c.op = CMD_MINDEX;
      OPC_ROLL:    c.op = CMD_ROLL;
      OPC_WS:      c.op = CMD_WS;
      OPC_RS:      c.op = CMD_RS;
      OPC_LT:      begin c.op = CMD_BIN; c.alu = ALU_LT; end
      OPC_LTEQ:    begin c.op = CMD_BIN; c.alu = ALU_LTEQ; end
      OPC_GT:      begin c.op = CMD_BIN; c.alu = ALU_GT; end
      OPC_GTEQ:    begin c.op = CMD_BIN; c.alu = ALU_GTEQ; end
      OPC_EQ:      begin c.op = CMD_BIN; c.alu = ALU_EQ; end
      OPC_NEQ:     begin c.op = CMD_BIN; c.alu = ALU_NEQ; end
      OPC_AND:     begin c.op = CMD_BIN; c.alu = ALU_AND; end
      OPC_OR:      begin c.op = CMD_BIN; c.alu = ALU_OR; end
      OPC_ADD:     begin c.op = CMD_BIN; c.alu = ALU_ADD; end
      OPC_SUB:     begin c.op = CMD_BIN; c.alu = ALU_SUB; end
      OPC_DIV:     begin c.op = CMD_BIN; c.alu = ALU_DIV; end
      OPC_MUL:     begin c.op = CMD_BIN; c.alu = ALU_MUL; end
      OPC_MAX:     begin c.op = CMD_BIN; c.alu = ALU_MAX; end
      OPC_MIN:     begin c.op = CMD_BIN; c.alu = ALU_MIN; end
      OPC_NOT:     begin c.op = CMD_UNARY; c.alu = ALU_NOT; end
      OPC_ABS:     begin c.op = CMD_UNARY; c.alu = ALU_ABS; end
      OPC_NEG:     begin c.op = CMD_UNARY; c.alu = ALU_NEG; end
      OPC_FLOOR:   begin c.op = CMD_UNARY; c.alu = ALU_FLOOR; end
      OPC_CEILING: begin c.op = CMD_UNARY; c.alu = ALU_CEIL; end
      OPC_GETINFO: begin c.op = CMD_UNARY; c.alu = ALU_ZERO; end
      default:     c.op = CMD_UNSUP;
    endcase
    return c;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    if (accept_i) begin
      unique case (state_q)
        FS_OPC: begin
          if (code_byte_i == OPC_NPUSHB) state_d = FS_CNT_B;
          else if (code_byte_i == OPC_NPUSHW) state_d = FS_CNT_W;
          else if (push_b) state_d = FS_BYTE;
          else if (push_w) state_d = FS_WHI;
        end
        FS_CNT_B: state_d = (code_byte_i == 8'd0) ? FS_OPC : FS_BYTE;
        FS_CNT_W: state_d = (code_byte_i == 8'd0) ? FS_OPC : FS_WHI;
        FS_BYTE:  state_d = (rem_q == 9'd1) ? FS_OPC : FS_BYTE;
        FS_WHI:   state_d = FS_WLO;
        FS_WLO:   state_d = (rem_q == 9'd1) ? FS_OPC : FS_WHI;
        default:  state_d = FS_OPC;
      endcase
    end
  end

  // command and counters
  always_comb begin
    rem_d = rem_q;
    hold_d = hold_q;
    cmd_o = classify(code_byte_i);
    unique case (state_q)
      FS_OPC: begin
        if (code_byte_i == OPC_NPUSHB || code_byte_i == OPC_NPUSHW) begin
          cmd_o.op = CMD_NOP;
        end else if (push_b || push_w) begin
          cmd_o.op = CMD_NOP;
          rem_d = {6'd0, code_byte_i[2:0]} + 9'd1;
        end
      end
      FS_CNT_B, FS_CNT_W: begin
        cmd_o.op = CMD_NOP;
        cmd_o.took = 1'b1;
        rem_d = {1'b0, code_byte_i};
      end
      FS_BYTE: begin
        cmd_o.op = CMD_PUSH;
        cmd_o.took = 1'b1;
        cmd_o.val = {24'd0, code_byte_i};
        rem_d = rem_q - 9'd1;
      end
      FS_WHI: begin
        cmd_o.op = CMD_NOP;
        cmd_o.took = 1'b1;
        hold_d = code_byte_i;
      end
      FS_WLO: begin
        cmd_o.op = CMD_PUSH;
        cmd_o.took = 1'b1;
        cmd_o.val = {{16{hold_q[7]}}, hold_q, code_byte_i};
        rem_d = rem_q - 9'd1;
      end
      default: cmd_o.op = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_OPC;
      rem_q <= '0;
      hold_q <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
      rem_q <= rem_d;
      hold_q <= hold_d;
    end
  end

endmodule

@@ design/fbsu_queue.sv @@
// ---------------------------------------------------------------------------
// fbsu_queue
// short command fifo between the decoder and the execution unit
// ---------------------------------------------------------------------------
module fbsu_queue import fbsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  cmd_t           mem_q [QUEUE_DEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QAW:0]   cnt_q;
  logic           wr_en, rd_en;

  assign wr_ready_o = cnt_q != (QAW+1)'(QUEUE_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr_en = wr_valid_i && wr_ready_o;
  assign rd_en = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wp_q <= wp_q + QAW'(1);
      if (rd_en) rp_q <= rp_q + QAW'(1);
      if (wr_en && !rd_en) cnt_q <= cnt_q + (QAW+1)'(1);
      else if (rd_en && !wr_en) cnt_q <= cnt_q - (QAW+1)'(1);
    end
  end

endmodule

@@ design/fbsu_div.sv @@
// ---------------------------------------------------------------------------
// fbsu_div
// radix-2 restoring divider for the 26.6 quotient, one bit per cycle
// ---------------------------------------------------------------------------
module fbsu_div import fbsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [37:0] dividend_i,
  input  logic [31:0] divisor_i,
  input  logic        neg_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  localparam int Steps = 38;

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q, div_q;
  logic [37:0] quo_q;
  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        ge;

  assign rem_sh = {rem_q, quo_q[37]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_q};
  assign ge     = !diff[33];

  assign done_o = done_q;
  assign quot_o = neg_q ? (32'd0 - quo_q[31:0]) : quo_q[31:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[36:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/fbsu_back.sv @@
// ---------------------------------------------------------------------------
// fbsu_back
// execution unit: operand stack, storage area, alu sequencing, result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fbsu_back import fbsu_pkg::*; #(
  parameter int STACK_DEPTH = 256,
  parameter int STORE_WORDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  cmd_t        cmd_i,
  output logic        init_done_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] top_value_o,
  output logic [8:0]  depth_o,
  output logic        read_unset_o,
  output logic        took_data_o
);

  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SAW = $clog2(STORE_WORDS);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  status_e     status_q, status_d, idle_st;
  logic [DW-1:0] depth_q, depth_d, dm1, dm2, dm3, cidx;
  logic [31:0] top_q, top_d, e2_q, e2_d, e3_q, e3_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [SAW-1:0] init_q, init_d;
  logic [63:0] prod_q, prod_d;
  logic        unset_q, unset_d;

  logic        out_valid_q, out_valid_d, out_unset_q, out_unset_d, out_took_q, out_took_d;
  logic [2:0]  out_status_q, out_status_d;
  logic [31:0] out_top_q, out_top_d;
  logic [8:0]  out_depth_q, out_depth_d;

  logic [31:0] stk_mem [STACK_DEPTH];
  logic [32:0] st_mem [STORE_WORDS];
  logic          stk_we, st_we;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [31:0]   stk_wdata, stk_rdata_q;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [32:0]   st_wdata, st_rdata_q;

  logic        d0, lt2, lt3, full, cidx_bad, top_idx_ok, rd_idx_ok, out_free;
  logic [31:0] bin_res, un_res, rs_res, mag_a, mag_b;
  logic        div_start, div_done;
  logic [31:0] div_quot;

  function automatic logic [31:0] alu_bin(alu_e f, logic [31:0] e2, logic [31:0] e1);
    logic signed [31:0] a, b;
    logic [31:0] r;
    a = e2;
    b = e1;
    case (f)
      ALU_LT:   r = {31'd0, a < b};
      ALU_LTEQ: r = {31'd0, a <= b};
      ALU_GT:   r = {31'd0, a > b};
      ALU_GTEQ: r = {31'd0, a >= b};
      ALU_EQ:   r = {31'd0, e2 == e1};
      ALU_NEQ:  r = {31'd0, e2 != e1};
      ALU_AND:  r = {31'd0, (e2 != 32'd0) && (e1 != 32'd0)};
      ALU_OR:   r = {31'd0, (e2 != 32'd0) || (e1 != 32'd0)};
      ALU_ADD:  r = e2 + e1;
      ALU_SUB:  r = e2 - e1;
      ALU_MAX:  r = (b > a) ? e1 : e2;
      ALU_MIN:  r = (b < a) ? e1 : e2;
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] alu_un(alu_e f, logic [31:0] e1);
    logic [31:0] r;
    case (f)
      ALU_NOT:   r = {31'd0, e1 == 32'd0};
      ALU_ABS:   r = e1[31] ? (32'd0 - e1) : e1;
      ALU_NEG:   r = 32'd0 - e1;
      ALU_FLOOR: r = e1 & FRAC_MASK;
      ALU_CEIL:  r = (e1 + CEIL_ADD) & FRAC_MASK;
      default:   r = '0;
    endcase
    return r;
  endfunction

  assign dm1 = depth_q - DW'(1);
  assign dm2 = depth_q - DW'(2);
  assign dm3 = depth_q - DW'(3);
  assign d0   = depth_q == '0;
  assign lt2  = depth_q < DW'(2);
  assign lt3  = depth_q < DW'(3);
  assign full = depth_q == DW'(STACK_DEPTH);
  // index k picks the entry k places below the one holding k
  assign cidx_bad   = (top_q == 32'd0) || (top_q > 32'(dm1));
  assign cidx       = dm1 - top_q[DW-1:0];
  assign top_idx_ok = top_q < 32'(STORE_WORDS);
  assign rd_idx_ok  = stk_rdata_q < 32'(STORE_WORDS);
  assign bin_res = alu_bin(cmd_q.alu, stk_rdata_q, top_q);
  assign un_res  = alu_un(cmd_i.alu, top_q);
  assign rs_res  = st_rdata_q[32] ? st_rdata_q[31:0] : 32'd0;
  assign mag_a = stk_rdata_q[31] ? (32'd0 - stk_rdata_q) : stk_rdata_q;
  assign mag_b = top_q[31] ? (32'd0 - top_q) : top_q;
  assign out_free = !out_valid_q || out_ready_i;

  fbsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag_a, 6'd0}),
    .divisor_i  (mag_b),
    .neg_i      (stk_rdata_q[31] ^ top_q[31]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // status of a command at dispatch
  always_comb begin
    unique case (cmd_i.op)
      CMD_PUSH:   idle_st = full ? ST_OVER : ST_OK;
      CMD_DUP:    idle_st = d0 ? ST_UNDER : (full ? ST_OVER : ST_OK);
      CMD_POP, CMD_UNARY: idle_st = d0 ? ST_UNDER : ST_OK;
      CMD_SWAP, CMD_BIN, CMD_WS: idle_st = lt2 ? ST_UNDER : ST_OK;
      CMD_CINDEX, CMD_MINDEX: idle_st = (d0 || cidx_bad) ? ST_UNDER : ST_OK;
      CMD_ROLL:   idle_st = lt3 ? ST_UNDER : ST_OK;
      CMD_RS:     idle_st = d0 ? ST_UNDER : (top_idx_ok ? ST_OK : ST_BADIDX);
      CMD_UNSUP:  idle_st = ST_UNSUP;
      default:    idle_st = ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_INIT: if (init_q == SAW'(STORE_WORDS - 1)) state_d = BS_IDLE;
      BS_IDLE: begin
        if (q_valid_i) begin
          if (idle_st != ST_OK) begin
            state_d = BS_DONE;
          end else begin
            case (cmd_i.op) inside
              CMD_POP: state_d = (dm1 != '0) ? BS_TOPWT : BS_DONE;
              CMD_SWAP, CMD_CINDEX, CMD_MINDEX, CMD_BIN, CMD_WS, CMD_RS:
                state_d = BS_EXEC;
              CMD_ROLL: state_d = BS_RD2;
              default:  state_d = BS_DONE;
            endcase
          end
        end
      end
      BS_RD2: state_d = BS_EXEC;
      BS_EXEC: begin
        case (cmd_q.op)
          CMD_SWAP, CMD_ROLL: state_d = BS_WR2;
          CMD_MINDEX: state_d = BS_MOVE_RD;
          CMD_BIN: begin
            if (cmd_q.alu == ALU_DIV) state_d = (top_q == 32'd0) ? BS_DONE : BS_DIVWT;
            else if (cmd_q.alu == ALU_MUL) state_d = BS_MUL;
            else state_d = BS_DONE;
          end
          CMD_WS: state_d = (rd_idx_ok && dm2 != '0) ? BS_TOPWT : BS_DONE;
          default: state_d = BS_DONE;
        endcase
      end
      BS_MUL: state_d = BS_DONE;
      BS_DIVWT: if (div_done) state_d = BS_DONE;
      BS_MOVE_RD: state_d = (idx_q == dm2[AW-1:0]) ? BS_DONE : BS_MOVE_WR;
      BS_MOVE_WR: state_d = BS_MOVE_RD;
      BS_WR2: state_d = (cmd_q.op == CMD_ROLL) ? BS_WR3 : BS_DONE;
      BS_WR3: state_d = BS_DONE;
      BS_TOPWT: state_d = BS_DONE;
      BS_DONE: if (out_free) state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_d = cmd_q;
    status_d = status_q;
    depth_d = depth_q;
    top_d = top_q;
    e2_d = e2_q;
    e3_d = e3_q;
    idx_d = idx_q;
    init_d = init_q;
    prod_d = prod_q;
    unset_d = unset_q;
    stk_we = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = '0;
    st_we = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_raddr = '0;
    div_start = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_top_d = out_top_q;
    out_depth_d = out_depth_q;
    out_unset_d = out_unset_q;
    out_took_d = out_took_q;
    unique case (state_q)
      BS_INIT: begin
        st_we = 1'b1;
        st_waddr = init_q;
        init_d = init_q + SAW'(1);
      end
      BS_IDLE: begin
        if (q_valid_i) begin
          cmd_d = cmd_i;
          status_d = idle_st;
          unset_d = 1'b0;
          if (idle_st == ST_OK) begin
            case (cmd_i.op)
              CMD_PUSH, CMD_DUP: begin
                stk_we = 1'b1;
                stk_waddr = depth_q[AW-1:0];
                stk_wdata = (cmd_i.op == CMD_PUSH) ? cmd_i.val : top_q;
                top_d = stk_wdata;
                depth_d = depth_q + DW'(1);
              end
              CMD_POP: begin
                depth_d = dm1;
                stk_raddr = dm2[AW-1:0];
              end
              CMD_CLEAR: depth_d = '0;
              CMD_SWAP, CMD_BIN, CMD_WS: stk_raddr = dm2[AW-1:0];
              CMD_CINDEX, CMD_MINDEX: begin
                stk_raddr = cidx[AW-1:0];
                idx_d = cidx[AW-1:0];
              end
              CMD_ROLL: stk_raddr = dm3[AW-1:0];
              CMD_UNARY: begin
                stk_we = 1'b1;
                stk_waddr = dm1[AW-1:0];
                stk_wdata = un_res;
                top_d = un_res;
              end
              CMD_RS: st_raddr = top_q[SAW-1:0];
              default: ;
            endcase
          end
        end
      end
      BS_RD2: begin
        e3_d = stk_rdata_q;
        stk_raddr = dm2[AW-1:0];
      end
      BS_EXEC: begin
        case (cmd_q.op)
          CMD_SWAP: begin
            stk_we = 1'b1;
            stk_waddr = dm2[AW-1:0];
            stk_wdata = top_q;
            top_d = stk_rdata_q;
            e2_d = stk_rdata_q;
          end
          CMD_CINDEX: begin
            stk_we = 1'b1;
            stk_waddr = dm1[AW-1:0];
            stk_wdata = stk_rdata_q;
            top_d = stk_rdata_q;
          end
          CMD_MINDEX: e2_d = stk_rdata_q;
          CMD_ROLL: begin
            stk_we = 1'b1;
            stk_waddr = dm3[AW-1:0];
            stk_wdata = stk_rdata_q;
          end
          CMD_BIN: begin
            if (cmd_q.alu == ALU_DIV) begin
              if (top_q == 32'd0) status_d = ST_DIV0;
              else div_start = 1'b1;
            end else if (cmd_q.alu == ALU_MUL) begin
              prod_d = 64'($signed(stk_rdata_q) * $signed(top_q));
            end else begin
              stk_we = 1'b1;
              stk_waddr = dm2[AW-1:0];
              stk_wdata = bin_res;
              top_d = bin_res;
              depth_d = dm1;
            end
          end
          CMD_WS: begin
            if (!rd_idx_ok) begin
              status_d = ST_BADIDX;
            end else begin
              st_we = 1'b1;
              st_waddr = stk_rdata_q[SAW-1:0];
              st_wdata = {1'b1, top_q};
              depth_d = dm2;
              stk_raddr = dm3[AW-1:0];
            end
          end
          CMD_RS: begin
            unset_d = !st_rdata_q[32];
            stk_we = 1'b1;
            stk_waddr = dm1[AW-1:0];
            stk_wdata = rs_res;
            top_d = rs_res;
          end
          default: ;
        endcase
      end
      BS_MUL: begin
        // arithmetic shift gives floor of the product over 64
        stk_we = 1'b1;
        stk_waddr = dm2[AW-1:0];
        stk_wdata = prod_q[37:6];
        top_d = prod_q[37:6];
        depth_d = dm1;
      end
      BS_DIVWT: begin
        if (div_done) begin
          stk_we = 1'b1;
          stk_waddr = dm2[AW-1:0];
          stk_wdata = div_quot;
          top_d = div_quot;
          depth_d = dm1;
        end
      end
      BS_MOVE_RD: begin
        if (idx_q == dm2[AW-1:0]) begin
          stk_we = 1'b1;
          stk_waddr = dm2[AW-1:0];
          stk_wdata = e2_q;
          top_d = e2_q;
          depth_d = dm1;
        end else begin
          stk_raddr = idx_q + AW'(1);
        end
      end
      BS_MOVE_WR: begin
        stk_we = 1'b1;
        stk_waddr = idx_q;
        stk_wdata = stk_rdata_q;
        idx_d = idx_q + AW'(1);
      end
      BS_WR2: begin
        stk_we = 1'b1;
        if (cmd_q.op == CMD_ROLL) begin
          stk_waddr = dm2[AW-1:0];
          stk_wdata = top_q;
        end else begin
          stk_waddr = dm1[AW-1:0];
          stk_wdata = e2_q;
        end
      end
      BS_WR3: begin
        stk_we = 1'b1;
        stk_waddr = dm1[AW-1:0];
        stk_wdata = e3_q;
        top_d = e3_q;
      end
      BS_TOPWT: top_d = stk_rdata_q;
      BS_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_status_d = status_q;
          out_top_d = d0 ? 32'd0 : top_q;
          out_depth_d = 9'(depth_q);
          out_unset_d = unset_q;
          out_took_d = cmd_q.took;
        end
      end
      default: ;
    endcase
  end

  assign q_ready_o   = state_q == BS_IDLE;
  assign init_done_o = state_q != BS_INIT;
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign top_value_o  = out_top_q;
  assign depth_o      = out_depth_q;
  assign read_unset_o = out_unset_q;
  assign took_data_o  = out_took_q;

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    st_rdata_q <= st_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    status_q <= status_d;
    top_q <= top_d;
    e2_q <= e2_d;
    e3_q <= e3_d;
    idx_q <= idx_d;
    prod_q <= prod_d;
    unset_q <= unset_d;
    out_status_q <= out_status_d;
    out_top_q <= out_top_d;
    out_depth_q <= out_depth_d;
    out_unset_q <= out_unset_d;
    out_took_q <= out_took_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_INIT;
      depth_q <= '0;
      init_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      init_q <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FBSU_NEVER(depth_in_range_a, clk_i, rst_ni, depth_q > DW'(STACK_DEPTH))
  `FBSU_ASSERT(done_holds_a, clk_i, rst_ni, (state_q == BS_DONE && out_valid_q && !out_ready_i) |=> (state_q == BS_DONE))
  `FBSU_ASSERT(div_done_state_a, clk_i, rst_ni, div_done |-> (state_q == BS_DIVWT))

endmodule

@@ design/font_bytecode_stack_unit_core.sv @@
// ---------------------------------------------------------------------------
// font_bytecode_stack_unit_core
// stack part of a glyph-hinting bytecode machine, one code byte per transaction
// ---------------------------------------------------------------------------
// code bytes enter on in_valid_i/in_ready_i-style handshake (in_valid_i, in_ready_o);
// each accepted byte yields exactly one result transaction on out_valid_o/out_ready_i
// carrying status, top of stack, depth, read_unset and took_data.
// unless stalled, the decoder takes a byte per cycle into a four-entry command queue; the
// execution unit works one command at a time against single-port stack memory.
// push, dup, clear, unary ops, push bookkeeping and errors caught at dispatch go
// straight to the result; pop and ws may reload the new top; binary ops, cindex,
// rs and ws take an execute step, swap then a second write, mul a multiply step,
// roll a second read and two more writes, div a divider run (one quotient bit per
// cycle, 38 bits), mindex a read and a write per moved entry. sustained rate is set
// by the execution unit's sequencing of the stack memory. after reset a clearing
// pass over all STORE_WORDS words wipes the storage written flags; in_ready_o stays
// low until it ends. stack depth resets to zero. a stalled receiver holds the result
// register; the queue keeps taking bytes until it fills, then in_ready_o drops.
// ---------------------------------------------------------------------------
module font_bytecode_stack_unit_core import fbsu_pkg::*; #(
  parameter int STACK_DEPTH = 256,
  parameter int STORE_WORDS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         code_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] top_value_o,
  output logic [8:0]         depth_o,
  output logic               read_unset_o,
  output logic               took_data_o
);

  cmd_t front_cmd, q_cmd;
  logic q_wr_ready, q_rd_valid, q_rd_ready, init_done, accept;

  assign in_ready_o = q_wr_ready && init_done;
  assign accept = in_valid_i && in_ready_o;

  fbsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .code_byte_i (code_byte_i),
    .cmd_o       (front_cmd)
  );

  fbsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (accept),
    .wr_ready_o (q_wr_ready),
    .wr_data_i  (front_cmd),
    .rd_valid_o (q_rd_valid),
    .rd_ready_i (q_rd_ready),
    .rd_data_o  (q_cmd)
  );

  fbsu_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_rd_valid),
    .q_ready_o    (q_rd_ready),
    .cmd_i        (q_cmd),
    .init_done_o  (init_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .top_value_o  (top_value_o),
    .depth_o      (depth_o),
    .read_unset_o (read_unset_o),
    .took_data_o  (took_data_o)
  );

endmodule
